// ----- src/i2cees_pkg.sv -----
// Package for the I2C EEPROM sequencer: codes, field widths, buffer sizing
// and the result word type. It has no dependencies of its own.
`default_nettype none

package i2cees_pkg;

   localparam int BUF_DEPTH = 256;
   localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

   localparam int RQ_DEPTH  = 3;
   localparam int RQ_CW     = 2;

   localparam logic [6:0] DEVICE_ADDR_RESET = 7'd80;

   typedef enum logic [1:0] {
      ACT_START  = 2'd0,
      ACT_LOAD   = 2'd1,
      ACT_STATUS = 2'd2
   } action_type;

   localparam logic [7:0] ST_START     = 8'h08;
   localparam logic [7:0] ST_RSTART    = 8'h10;
   localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
   localparam logic [7:0] ST_SLAW_NACK = 8'h20;
   localparam logic [7:0] ST_DATA_ACK  = 8'h28;
   localparam logic [7:0] ST_ARB_LOST  = 8'h38;
   localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
   localparam logic [7:0] ST_RX_ACK    = 8'h50;
   localparam logic [7:0] ST_RX_NACK   = 8'h58;
   localparam logic [7:0] ST_BUS_ERR   = 8'h00;

   typedef struct packed {
      logic       last;
      logic       rx_valid;
      logic       data_valid;
      logic [7:0] rx_byte;
      logic [7:0] rx_index;
      logic       done_res;
      logic       ctl_aa;
      logic       ctl_sto;
      logic       ctl_sta;
      logic       ctl_si;
      logic [7:0] data_byte;
   } rsp_type;

endpackage

`default_nettype wire

// ----- src/i2c_master_eeprom_sequencer.sv -----
// Top level of the I2C EEPROM sequencer: decodes start, load and bus status
// words into data and control writes. Depends on i2cees_pkg and i2cees_ram.
`default_nettype none

// Channel  Direction  Handshake          Contents
// req      in         tvalid/tready      tuser action, tdata command fields
// rsp      out        tvalid/tready      tuser flags, tdata bytes, tlast run end
// csr      in         wr_en              seven-bit device address
//
// Each accepted word is decoded in the cycle it is accepted; one word per cycle while req_tready is high.
// Results go to a three-entry queue; req_tready is high while it holds at most
// one result, so a word yielding two results can hold off the next word.
// Reset is synchronous; the transmit buffer RAM is not cleared and holds
// undefined data until loaded. Stalls on rsp back up only through the queue.

module i2c_master_eeprom_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // tdata: direction, word_addr, length, load_index, load_byte, status_code,
   // rx_data, zero fill
   input  wire logic [63:0] req_tdata,
   // tuser: action
   input  wire logic [1:0]  req_tuser,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata: data_byte, ctl_si, ctl_sta, ctl_sto, ctl_aa, done_res, rx_index,
   // rx_byte, zero fill
   output      logic [31:0] rsp_tdata,
   // tuser: data_valid, rx_valid
   output      logic [1:0]  rsp_tuser,
   output      logic        rsp_tlast,
   input  wire logic        csr_wr_en,
   input  wire logic [6:0]  csr_wr_data
);

   logic                       req_acc;
   i2cees_pkg::action_type     act;
   logic                       in_direction;
   logic [15:0]                in_word_addr;
   logic [8:0]                 in_length;
   logic [7:0]                 in_load_index;
   logic [7:0]                 in_load_byte;
   logic [7:0]                 in_status;
   logic [7:0]                 in_rx_data;

   logic [6:0]                 device_addr_ff;
   logic                       read_mode_ff, read_mode_in;
   logic [15:0]                target_addr_ff, target_addr_in;
   logic [8:0]                 xfer_length_ff, xfer_length_in;
   logic [8:0]                 byte_index_ff, byte_index_in;
   logic                       low_pending_ff, low_pending_in;

   logic                       buf_we;
   logic [i2cees_pkg::BUF_AW-1:0] buf_wr_addr;
   logic [i2cees_pkg::BUF_AW-1:0] buf_rd_addr;
   logic [7:0]                 buf_rd_data;
   logic                       byp_valid_ff;
   logic [7:0]                 byp_data_ff;
   logic [7:0]                 buf_byte;

   i2cees_pkg::rsp_type        res0, res1;
   logic [1:0]                 res_count;
   logic [8:0]                 index_inc;
   logic                       more;

   i2cees_pkg::rsp_type        queue_ff [i2cees_pkg::RQ_DEPTH];
   i2cees_pkg::rsp_type        queue_in [i2cees_pkg::RQ_DEPTH];
   logic [i2cees_pkg::RQ_CW-1:0] count_ff, count_in;
   logic [i2cees_pkg::RQ_CW-1:0] base;
   logic                       pop;

   assign act           = i2cees_pkg::action_type'(req_tuser);
   assign in_direction  = req_tdata[0];
   assign in_word_addr  = req_tdata[16:1];
   assign in_length     = req_tdata[25:17];
   assign in_load_index = req_tdata[33:26];
   assign in_load_byte  = req_tdata[41:34];
   assign in_status     = req_tdata[49:42];
   assign in_rx_data    = req_tdata[57:50];

   assign req_tready = (count_ff <= i2cees_pkg::RQ_CW'(1));
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;

   assign buf_we      = req_acc && (act == i2cees_pkg::ACT_LOAD) &&
                        (32'(in_load_index) < i2cees_pkg::BUF_DEPTH);
   assign buf_wr_addr = i2cees_pkg::BUF_AW'(in_load_index);
   assign buf_rd_addr = i2cees_pkg::BUF_AW'(byte_index_in);

   i2cees_ram #(
      .WIDTH (8),
      .DEPTH (i2cees_pkg::BUF_DEPTH)
   ) tx_buf (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (buf_wr_addr),
      .wr_data (in_load_byte),
      .rd_addr (buf_rd_addr),
      .rd_data (buf_rd_data)
   );

   // A load to the entry being read in the same cycle is forwarded.
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_valid_ff <= 1'b0;
      end else begin
         byp_valid_ff <= buf_we && (buf_wr_addr == buf_rd_addr);
      end
      byp_data_ff <= in_load_byte;
   end

   always_comb begin
      if (32'(byte_index_ff) >= i2cees_pkg::BUF_DEPTH) begin
         buf_byte = 8'h00;
      end else if (byp_valid_ff) begin
         buf_byte = byp_data_ff;
      end else begin
         buf_byte = buf_rd_data;
      end
   end

   assign index_inc = byte_index_ff + 9'd1;
   assign more      = ({1'b0, index_inc} + 10'd1) < {1'b0, xfer_length_ff};

   always_comb begin
      read_mode_in   = read_mode_ff;
      target_addr_in = target_addr_ff;
      xfer_length_in = xfer_length_ff;
      byte_index_in  = byte_index_ff;
      low_pending_in = low_pending_ff;
      res0           = '0;
      res1           = '0;
      res_count      = 2'd0;
      if (req_acc) begin
         unique case (act)
            i2cees_pkg::ACT_START: begin
               read_mode_in   = in_direction;
               target_addr_in = in_word_addr;
               xfer_length_in = in_length;
               byte_index_in  = 9'd0;
               res0.ctl_sta   = 1'b1;
               res_count      = 2'd1;
            end
            i2cees_pkg::ACT_STATUS: begin
               res0.ctl_si = 1'b1;
               unique case (in_status) inside
                  i2cees_pkg::ST_START: begin
                     res0.data_valid = 1'b1;
                     res0.data_byte  = {device_addr_ff, 1'b0};
                     res_count       = 2'd1;
                  end
                  i2cees_pkg::ST_SLAW_ACK: begin
                     res0.data_valid = 1'b1;
                     res0.data_byte  = target_addr_ff[15:8];
                     low_pending_in  = 1'b1;
                     res_count       = 2'd1;
                  end
                  i2cees_pkg::ST_SLAW_NACK: begin
                     res0.ctl_sta = 1'b1;
                     res0.ctl_sto = 1'b1;
                     res_count    = 2'd1;
                  end
                  i2cees_pkg::ST_DATA_ACK: begin
                     res_count = 2'd1;
                     if (!read_mode_ff && (byte_index_ff < xfer_length_ff)) begin
                        res0.data_valid = 1'b1;
                        res0.ctl_aa     = 1'b1;
                        if (low_pending_ff) begin
                           low_pending_in = 1'b0;
                           res0.data_byte = target_addr_ff[7:0];
                        end else begin
                           res0.data_byte = buf_byte;
                           byte_index_in  = index_inc;
                        end
                     end else if (read_mode_ff && (xfer_length_ff != 9'd0)) begin
                        if (low_pending_ff) begin
                           low_pending_in  = 1'b0;
                           res0.data_valid = 1'b1;
                           res0.data_byte  = target_addr_ff[7:0];
                        end else begin
                           res0.ctl_sta = 1'b1;
                        end
                     end else begin
                        res0.ctl_sto  = 1'b1;
                        res0.done_res = 1'b1;
                     end
                  end
                  i2cees_pkg::ST_ARB_LOST: begin
                     if (!read_mode_ff) begin
                        res0.ctl_sta = 1'b1;
                        res0.ctl_aa  = 1'b1;
                        res_count    = 2'd1;
                     end
                  end
                  i2cees_pkg::ST_BUS_ERR: begin
                     if (!read_mode_ff) begin
                        res0.ctl_sto = 1'b1;
                        res0.ctl_aa  = 1'b1;
                        res1.ctl_si  = 1'b1;
                        res1.ctl_aa  = 1'b1;
                        res_count    = 2'd2;
                     end
                  end
                  i2cees_pkg::ST_RSTART: begin
                     if (read_mode_ff) begin
                        res0.data_valid = 1'b1;
                        res0.data_byte  = {device_addr_ff, 1'b1};
                        res_count       = 2'd1;
                     end
                  end
                  i2cees_pkg::ST_SLAR_ACK: begin
                     if (read_mode_ff) begin
                        res0.ctl_aa = (xfer_length_ff > 9'd1);
                        res_count   = 2'd1;
                     end
                  end
                  i2cees_pkg::ST_RX_ACK, i2cees_pkg::ST_RX_NACK: begin
                     if (read_mode_ff) begin
                        byte_index_in = index_inc;
                        res0.rx_valid = 1'b1;
                        res0.rx_index = byte_index_ff[7:0];
                        res0.rx_byte  = in_rx_data;
                        res_count     = 2'd1;
                        if (in_status == i2cees_pkg::ST_RX_ACK) begin
                           res0.ctl_aa = more;
                        end else if (!more) begin
                           res0.ctl_sto  = 1'b1;
                           res0.done_res = 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
      if (res_count == 2'd2) begin
         res1.last = 1'b1;
      end else begin
         res0.last = 1'b1;
      end
   end

   always_comb begin
      base = count_ff - i2cees_pkg::RQ_CW'(pop);
      for (int i = 0; i < i2cees_pkg::RQ_DEPTH; i++) begin
         if (pop && (i < i2cees_pkg::RQ_DEPTH - 1)) begin
            queue_in[i] = queue_ff[i+1];
         end else begin
            queue_in[i] = queue_ff[i];
         end
         if ((res_count != 2'd0) && (i2cees_pkg::RQ_CW'(i) == base)) begin
            queue_in[i] = res0;
         end
         if ((res_count == 2'd2) && (i2cees_pkg::RQ_CW'(i) == base + 2'd1)) begin
            queue_in[i] = res1;
         end
      end
      count_in = base + i2cees_pkg::RQ_CW'(res_count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_addr_ff <= i2cees_pkg::DEVICE_ADDR_RESET;
         read_mode_ff   <= 1'b0;
         target_addr_ff <= '0;
         xfer_length_ff <= '0;
         byte_index_ff  <= '0;
         low_pending_ff <= 1'b0;
         count_ff       <= '0;
      end else begin
         if (csr_wr_en) begin
            device_addr_ff <= csr_wr_data;
         end
         read_mode_ff   <= read_mode_in;
         target_addr_ff <= target_addr_in;
         xfer_length_ff <= xfer_length_in;
         byte_index_ff  <= byte_index_in;
         low_pending_ff <= low_pending_in;
         count_ff       <= count_in;
      end
      queue_ff <= queue_in;
   end

   assign rsp_tdata = {3'b000, queue_ff[0].rx_byte, queue_ff[0].rx_index,
                       queue_ff[0].done_res, queue_ff[0].ctl_aa, queue_ff[0].ctl_sto,
                       queue_ff[0].ctl_sta, queue_ff[0].ctl_si, queue_ff[0].data_byte};
   assign rsp_tuser = {queue_ff[0].rx_valid, queue_ff[0].data_valid};
   assign rsp_tlast = queue_ff[0].last;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= i2cees_pkg::RQ_CW'(i2cees_pkg::RQ_DEPTH))
      else $error("result queue overflow");

   a_start_clears_index: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (act == i2cees_pkg::ACT_START)) |=> (byte_index_ff == 9'd0))
      else $error("start did not clear the byte pointer");

   a_addr_pending: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (act == i2cees_pkg::ACT_STATUS) &&
       (in_status == i2cees_pkg::ST_SLAW_ACK)) |=> low_pending_ff)
      else $error("low address byte not marked pending");

   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (count_ff <= i2cees_pkg::RQ_CW'(i2cees_pkg::RQ_DEPTH)) &&
                  ($past(count_ff) <= i2cees_pkg::RQ_CW'(1)))
      else $error("word accepted without queue room");

endmodule

`default_nettype wire

// ----- src/i2cees_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the transmit buffer of the EEPROM sequencer.
`default_nettype none

module i2cees_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
